[rtl/assert_macros.svh]
// Assertion macros shared by the map zone parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is asserted.
`define CMZP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cmzp assertion failed");
// Same check with a caller-supplied message.
`define CMZP_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define CMZP_ASSERT(lbl, prop)
`define CMZP_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

[rtl/cmzp_pkg.sv]
// Types, codes and constants of the chunked map zone parser.
`default_nettype none

package cmzp_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SIG,
        PH_VER,
        PH_SECHDR,
        PH_BODY,
        PH_RECHDR,
        PH_NAME,
        PH_OVERRUN,
        PH_DEAD
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_ZONE_HDR = 2'd0;
    localparam logic [1:0] KIND_NAME     = 2'd1;
    localparam logic [1:0] KIND_SECTION  = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    // Final status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_TRUNC_VER = 3'd2;
    localparam logic [2:0] ST_PAST_END  = 3'd3;
    localparam logic [2:0] ST_OVERRUN   = 3'd4;
    localparam logic [2:0] ST_NO_ZONE   = 3'd5;

    // Tag "ZONE" with the first byte in the low bits.
    localparam logic [31:0] ZONE_TAG = 32'h454E_4F5A;

    localparam int REC_HDR_LEN = 6;
    localparam int SEC_HDR_LEN = 8;
    localparam logic [2:0] REC_HDR_LAST = 3'(REC_HDR_LEN - 1);
    localparam logic [2:0] SEC_HDR_LAST = 3'(SEC_HDR_LEN - 1);
    localparam int REC_FIELDS = REC_HDR_LEN - 1;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  zone_code;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [7:0]  name_len;
        logic [31:0] section_tag;
        logic [31:0] value;
        logic [2:0]  status;
        logic        last_of_run;
    } result_t;

    // Up to two result words produced by one input byte.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Signature bytes "GBMP".
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h47;
            2'd1: b = 8'h42;
            2'd2: b = 8'h4D;
            2'd3: b = 8'h50;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/cmzp_stream_if.sv]
// Valid/ready channel interfaces for input bytes and result words.
`default_nettype none

interface cmzp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface cmzp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  zone_code;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [7:0]  name_len;
    logic [31:0] section_tag;
    logic [31:0] value;
    logic [2:0]  status;
    logic        last_of_run;

    modport source (
        output valid, output kind, output zone_code, output pos_x, output pos_y,
        output width, output height, output name_len, output section_tag,
        output value, output status, output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input zone_code, input pos_x, input pos_y,
        input width, input height, input name_len, input section_tag,
        input value, input status, input last_of_run, output ready
    );
endinterface

`default_nettype wire

[rtl/cmzp_parse.sv]
// Byte-at-a-time parser state and result word generation.
`default_nettype none
`include "assert_macros.svh"

module cmzp_parse (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic            end_of_file,
    output cmzp_pkg::push_t      push
);

    cmzp_pkg::phase_t phase_reg, phase_step, phase_next;
    logic [2:0]  fc_reg, fc_step, fc_next;
    logic        zone_seen_reg, zone_seen_step, zone_seen_next;
    logic [2:0]  error_reg, error_step, error_next;
    logic [31:0] tag_reg, tag_next;
    logic [23:0] size_reg, size_next;
    logic [31:0] left_reg, left_next;
    logic [7:0]  rec_reg [cmzp_pkg::REC_FIELDS];
    logic [7:0]  rec_next [cmzp_pkg::REC_FIELDS];
    logic [7:0]  name_left_reg, name_left_next;
    logic [15:0] version_reg, version_next;

    logic [31:0] left_dec;
    logic [31:0] full_size;
    logic        name_too_long;
    logic        eof_now;

    cmzp_pkg::result_t main_word;
    cmzp_pkg::result_t status_word;
    logic              main_valid;
    logic [2:0]        st;

    // Phase after a zone record: next section, short tail, or next record.
    function automatic cmzp_pkg::phase_t zone_phase(input logic [31:0] sl);
        cmzp_pkg::phase_t p;
        if (sl == 32'd0) begin
            p = cmzp_pkg::PH_SECHDR;
        end
        else if (sl < 32'(cmzp_pkg::REC_HDR_LEN)) begin
            p = cmzp_pkg::PH_BODY;
        end
        else begin
            p = cmzp_pkg::PH_RECHDR;
        end
        return p;
    endfunction

    assign left_dec      = left_reg - 32'd1;
    assign full_size     = {data_byte, size_reg};
    assign name_too_long = {24'd0, data_byte} > left_dec;
    assign eof_now       = accept && end_of_file;

    // Next state for one accepted byte.
    always_comb
    begin
        phase_step     = phase_reg;
        fc_step        = fc_reg;
        zone_seen_step = zone_seen_reg;
        error_step     = error_reg;
        tag_next       = tag_reg;
        size_next      = size_reg;
        left_next      = left_reg;
        rec_next       = rec_reg;
        name_left_next = name_left_reg;
        version_next   = version_reg;
        if (accept)
        begin
            unique case (phase_reg)
                cmzp_pkg::PH_SIG:
                begin
                    if (data_byte != cmzp_pkg::sig_byte(fc_reg[1:0]))
                    begin
                        error_step = cmzp_pkg::ST_BAD_SIG;
                        phase_step = cmzp_pkg::PH_DEAD;
                    end
                    else if (fc_reg[1:0] == 2'd3)
                    begin
                        phase_step = cmzp_pkg::PH_VER;
                        fc_step    = 3'd0;
                    end
                    else
                    begin
                        fc_step = fc_reg + 3'd1;
                    end
                end
                cmzp_pkg::PH_VER:
                begin
                    if (fc_reg == 3'd0)
                    begin
                        version_next = {8'd0, data_byte};
                        fc_step      = 3'd1;
                    end
                    else
                    begin
                        version_next[15:8] = data_byte;
                        phase_step         = cmzp_pkg::PH_SECHDR;
                        fc_step            = 3'd0;
                    end
                end
                cmzp_pkg::PH_SECHDR:
                begin
                    if (fc_reg == cmzp_pkg::SEC_HDR_LAST)
                    begin
                        left_next = full_size;
                        fc_step   = 3'd0;
                        if (tag_reg == cmzp_pkg::ZONE_TAG)
                        begin
                            zone_seen_step = 1'b1;
                            phase_step     = zone_phase(full_size);
                        end
                        else
                        begin
                            phase_step = (full_size != 32'd0) ? cmzp_pkg::PH_BODY
                                                              : cmzp_pkg::PH_SECHDR;
                        end
                    end
                    else
                    begin
                        // Bytes overwrite their lane, so no clearing is needed.
                        if (!fc_reg[2])
                        begin
                            tag_next[{fc_reg[1:0], 3'b000} +: 8] = data_byte;
                        end
                        else
                        begin
                            size_next[{fc_reg[1:0], 3'b000} +: 8] = data_byte;
                        end
                        fc_step = fc_reg + 3'd1;
                    end
                end
                cmzp_pkg::PH_BODY:
                begin
                    left_next = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        phase_step = cmzp_pkg::PH_SECHDR;
                        fc_step    = 3'd0;
                    end
                end
                cmzp_pkg::PH_RECHDR:
                begin
                    left_next = left_dec;
                    if (fc_reg != cmzp_pkg::REC_HDR_LAST)
                    begin
                        rec_next[fc_reg] = data_byte;
                        fc_step          = fc_reg + 3'd1;
                    end
                    else if (name_too_long)
                    begin
                        error_step = cmzp_pkg::ST_OVERRUN;
                        phase_step = (left_dec != 32'd0) ? cmzp_pkg::PH_OVERRUN
                                                         : cmzp_pkg::PH_DEAD;
                    end
                    else
                    begin
                        name_left_next = data_byte;
                        fc_step        = 3'd0;
                        phase_step     = (data_byte == 8'd0) ? zone_phase(left_dec)
                                                             : cmzp_pkg::PH_NAME;
                    end
                end
                cmzp_pkg::PH_NAME:
                begin
                    left_next      = left_dec;
                    name_left_next = name_left_reg - 8'd1;
                    if (name_left_reg == 8'd1)
                    begin
                        fc_step    = 3'd0;
                        phase_step = zone_phase(left_dec);
                    end
                end
                cmzp_pkg::PH_OVERRUN:
                begin
                    left_next = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        phase_step = cmzp_pkg::PH_DEAD;
                    end
                end
                cmzp_pkg::PH_DEAD:
                begin
                end
            endcase
        end

        // The final byte returns the control state to its reset values.
        phase_next     = eof_now ? cmzp_pkg::PH_SIG : phase_step;
        fc_next        = eof_now ? 3'd0 : fc_step;
        zone_seen_next = eof_now ? 1'b0 : zone_seen_step;
        error_next     = eof_now ? cmzp_pkg::ST_OK : error_step;
    end

    // Result words for one accepted byte.
    always_comb
    begin
        main_word   = '0;
        status_word = '0;
        main_valid  = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                cmzp_pkg::PH_SECHDR:
                begin
                    if (fc_reg == cmzp_pkg::SEC_HDR_LAST && tag_reg != cmzp_pkg::ZONE_TAG)
                    begin
                        main_valid            = 1'b1;
                        main_word.kind        = cmzp_pkg::KIND_SECTION;
                        main_word.section_tag = tag_reg;
                        main_word.value       = full_size;
                    end
                end
                cmzp_pkg::PH_RECHDR:
                begin
                    if (fc_reg == cmzp_pkg::REC_HDR_LAST && !name_too_long)
                    begin
                        main_valid          = 1'b1;
                        main_word.kind      = cmzp_pkg::KIND_ZONE_HDR;
                        main_word.zone_code = rec_reg[0];
                        main_word.pos_x     = rec_reg[1];
                        main_word.pos_y     = rec_reg[2];
                        main_word.width     = rec_reg[3];
                        main_word.height    = rec_reg[4];
                        main_word.name_len  = data_byte;
                    end
                end
                cmzp_pkg::PH_NAME:
                begin
                    main_valid      = 1'b1;
                    main_word.kind  = cmzp_pkg::KIND_NAME;
                    main_word.value = {24'd0, data_byte};
                end
                default:
                begin
                end
            endcase
        end
        main_word.last_of_run = !end_of_file;

        // Final status from the state left by this byte.
        if (error_step != cmzp_pkg::ST_OK)
        begin
            st = (phase_step == cmzp_pkg::PH_OVERRUN && left_next != 32'd0)
                 ? cmzp_pkg::ST_PAST_END : error_step;
        end
        else
        begin
            unique case (phase_step)
                cmzp_pkg::PH_SIG:    st = cmzp_pkg::ST_BAD_SIG;
                cmzp_pkg::PH_VER:    st = cmzp_pkg::ST_TRUNC_VER;
                cmzp_pkg::PH_SECHDR: st = zone_seen_step ? cmzp_pkg::ST_OK
                                                         : cmzp_pkg::ST_NO_ZONE;
                default:             st = cmzp_pkg::ST_PAST_END;
            endcase
        end
        status_word.kind        = cmzp_pkg::KIND_STATUS;
        status_word.status      = st;
        status_word.value       = (st == cmzp_pkg::ST_OK) ? {16'd0, version_next} : 32'd0;
        status_word.last_of_run = 1'b1;

        push.count  = {1'b0, main_valid} + {1'b0, eof_now};
        push.first  = main_valid ? main_word : status_word;
        push.second = status_word;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cmzp_pkg::PH_SIG;
            fc_reg        <= 3'd0;
            zone_seen_reg <= 1'b0;
            error_reg     <= cmzp_pkg::ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            fc_reg        <= fc_next;
            zone_seen_reg <= zone_seen_next;
            error_reg     <= error_next;
        end
    end

    // Header bytes and counters; each is written before it is read.
    always_ff @(posedge clk)
    begin
        tag_reg       <= tag_next;
        size_reg      <= size_next;
        left_reg      <= left_next;
        rec_reg       <= rec_next;
        name_left_reg <= name_left_next;
        version_reg   <= version_next;
    end

    // An error code is only held while the parser is skipping to the end.
    `CMZP_ASSERT(a_error_phase,
        (error_reg != cmzp_pkg::ST_OK) |->
        (phase_reg == cmzp_pkg::PH_DEAD || phase_reg == cmzp_pkg::PH_OVERRUN))
    // Name bytes are only expected while some remain.
    `CMZP_ASSERT(a_name_left, (phase_reg == cmzp_pkg::PH_NAME) |-> (name_left_reg != 8'd0))
    // The final byte always leaves the parser at the start of a new file.
    `CMZP_ASSERT_MSG(a_eof_reset,
        eof_now |=> (phase_reg == cmzp_pkg::PH_SIG && fc_reg == 3'd0),
        "parser did not restart after end of file")

endmodule

`default_nettype wire

[rtl/cmzp_out_fifo.sv]
// Small result queue taking up to two words per cycle and giving one.
`default_nettype none
`include "assert_macros.svh"

module cmzp_out_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmzp_pkg::push_t   push,
    input  wire logic              pop,
    output cmzp_pkg::result_t      head,
    output logic                   not_empty,
    output logic                   room
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmzp_pkg::result_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next, wr_second;
    logic [CW-1:0] count_reg, count_next;
    logic          pop_now;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign wr_second = ptr_inc(wr_reg);
    assign pop_now   = pop && not_empty;
    assign not_empty = count_reg != '0;
    assign room      = count_reg <= CW'(DEPTH - 2);
    assign head      = mem_reg[rd_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        unique case (push.count)
            2'd0:    wr_next = wr_reg;
            2'd1:    wr_next = wr_second;
            default: wr_next = ptr_inc(wr_second);
        endcase
        rd_next    = pop_now ? ptr_inc(rd_reg) : rd_reg;
        count_next = count_reg + CW'(push.count) - CW'(pop_now);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_second] <= push.second;
        end
    end

    `CMZP_ASSERT(a_no_overflow, count_reg <= CW'(DEPTH))
    `CMZP_ASSERT_MSG(a_push_room, (push.count != 2'd0) |-> room, "push without room")
    `CMZP_ASSERT(a_pop_count,
        (pop_now && push.count == 2'd0) |=> (count_reg == $past(count_reg) - CW'(1)))

endmodule

`default_nettype wire

[rtl/chunked_map_zone_parser.sv]
// Results of an accepted byte are registered in the result queue and offered on the output from its head.
// Throughput: one byte per cycle; the end-of-file byte may add a second word,
// and input ready is low while the result queue holds more than OUT_DEPTH-2 words.
// Reset: rst_n clears the parser to the signature phase and empties the queue at once;
// there is no clearing pass. Every end-of-file byte also returns the parser to that state.
`default_nettype none

module chunked_map_zone_parser #(
    parameter int OUT_DEPTH = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cmzp_in_if.sink       in_ch,
    cmzp_out_if.source    out_ch
);

    cmzp_pkg::push_t   push;
    cmzp_pkg::result_t head;
    logic              not_empty;
    logic              room;
    logic              accept;

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    cmzp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (in_ch.data_byte),
        .end_of_file (in_ch.end_of_file),
        .push        (push)
    );

    cmzp_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_ch.ready),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

    // Output word from the head of the queue.
    assign out_ch.valid       = not_empty;
    assign out_ch.kind        = head.kind;
    assign out_ch.zone_code   = head.zone_code;
    assign out_ch.pos_x       = head.pos_x;
    assign out_ch.pos_y       = head.pos_y;
    assign out_ch.width       = head.width;
    assign out_ch.height      = head.height;
    assign out_ch.name_len    = head.name_len;
    assign out_ch.section_tag = head.section_tag;
    assign out_ch.value       = head.value;
    assign out_ch.status      = head.status;
    assign out_ch.last_of_run = head.last_of_run;

endmodule

`default_nettype wire
